### sv/symbolic_mode_parser_unit_macros.svh
// Assertion macros used by the port-level checker.
`ifndef SYMBOLIC_MODE_PARSER_UNIT_MACROS_SVH
`define SYMBOLIC_MODE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define SMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SMP_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/smp_pkg.sv
// Shared types and constants of the symbolic mode parser.
package smp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int UMASK_W = 12;
    localparam int MODE_W  = 16;
    localparam int PERM_W  = 12;

    localparam logic [UMASK_W-1:0] UMASK_RESET = 12'o0022;

    // register index, taken from paddr[2]
    localparam logic REG_UMASK = 1'b0;

    localparam logic [PERM_W-1:0] MASK_USER  = 12'o5700;
    localparam logic [PERM_W-1:0] MASK_GROUP = 12'o2070;
    localparam logic [PERM_W-1:0] MASK_OTHER = 12'o0007;
    localparam logic [PERM_W-1:0] MASK_ALL   = 12'o1777;
    localparam logic [PERM_W-1:0] BIT_READ   = 12'o0444;
    localparam logic [PERM_W-1:0] BIT_WRITE  = 12'o0222;
    localparam logic [PERM_W-1:0] BIT_EXEC   = 12'o0111;
    localparam logic [PERM_W-1:0] BIT_SETID  = 12'o6000;
    localparam logic [PERM_W-1:0] BIT_STICKY = 12'o1000;
    localparam logic [MODE_W-1:0] TYPE_FIELD = 16'o170000;
    localparam logic [MODE_W-1:0] TYPE_DIR   = 16'o040000;

    typedef enum logic [2:0] {
        PH_OCTAL,
        PH_WHO,
        PH_PFIRST,
        PH_PERM,
        PH_AFTER,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    typedef enum logic [4:0] {
        CL_NUL,
        CL_DIGIT,
        CL_U,
        CL_G,
        CL_O,
        CL_A,
        CL_ADD,
        CL_SUB,
        CL_SET,
        CL_COMMA,
        CL_R,
        CL_W,
        CL_XL,
        CL_XU,
        CL_S,
        CL_T,
        CL_OTHER
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [2:0]        digit;
        logic              first;
        logic [MODE_W-1:0] start_mode;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

### sv/smp_front.sv
// Front end: input handshake and character classification.
module smp_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_symbol,
    input  logic                  s_is_first,
    input  logic [15:0]           s_start_mode,
    input  smp_pkg::q_status_t    q_status,
    output logic                  q_push,
    output smp_pkg::item_t        q_item
);
    import smp_pkg::*;

    cls_t cls;

    always_comb begin
        case (s_symbol)
            8'h00: cls = CL_NUL;
            "0", "1", "2", "3", "4", "5", "6", "7": cls = CL_DIGIT;
            "u": cls = CL_U;
            "g": cls = CL_G;
            "o": cls = CL_O;
            "a": cls = CL_A;
            "+": cls = CL_ADD;
            "-": cls = CL_SUB;
            "=": cls = CL_SET;
            ",": cls = CL_COMMA;
            "r": cls = CL_R;
            "w": cls = CL_W;
            "x": cls = CL_XL;
            "X": cls = CL_XU;
            "s": cls = CL_S;
            "t": cls = CL_T;
            default: cls = CL_OTHER;
        endcase
    end

    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready;

    assign q_item.cls        = cls;
    assign q_item.digit      = s_symbol[2:0];
    assign q_item.first      = s_is_first;
    assign q_item.start_mode = s_start_mode;

endmodule

### sv/smp_queue.sv
// Short queue of classified characters between front and back.
module smp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  smp_pkg::item_t     item_in,
    input  logic               pop,
    output smp_pkg::item_t     item_out,
    output smp_pkg::q_status_t status
);
    import smp_pkg::*;

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign item_out     = entries_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);

endmodule

### sv/smp_back.sv
// Back end: clause parser, mode update and result register.
module smp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smp_pkg::item_t                q_item,
    input  smp_pkg::q_status_t            q_status,
    output logic                          q_pop,
    input  logic [smp_pkg::UMASK_W-1:0]   umask,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_new_mode,
    output logic                          m_invalid
);
    import smp_pkg::*;

    phase_t              phase_reg, phase_next;
    op_t                 op_reg, op_next;
    logic [MODE_W-1:0]   oct_reg, oct_next;
    logic [PERM_W-1:0]   who_reg, who_next;
    logic [PERM_W-1:0]   perm_reg, perm_next;
    logic [MODE_W-1:0]   wm_reg, wm_next;
    logic                err_reg, err_next;
    logic                m_valid_reg, m_valid_next;
    logic [MODE_W-1:0]   m_new_mode_reg, m_new_mode_next;
    logic                m_invalid_reg, m_invalid_next;

    // state as seen by this character, after a string start
    phase_t              ph0;
    op_t                 op0;
    logic [MODE_W-1:0]   oct0, wm0;
    logic [PERM_W-1:0]   who0, perm0;
    logic                err0;
    cls_t                cls;

    logic in_oct, oct_digit, is_nul;
    logic who_path, who_letter, pf_copy, perm_path, perm_letter, ce;
    logic ce_op, ce_comma, emit;
    logic [PERM_W-1:0] who_lmask, who_base, perm_lbits, apply_bits, apply_t;
    logic [2:0]        cpy;
    logic              x_ok, apply_en;
    logic [MODE_W-1:0] wm_applied;
    op_t               op_sel;

    assign q_pop = !q_status.empty && (!m_valid_reg || m_ready);
    assign cls   = q_item.cls;

    always_comb begin
        ph0   = q_item.first ? PH_OCTAL : phase_reg;
        op0   = q_item.first ? OP_NONE  : op_reg;
        oct0  = q_item.first ? '0 : oct_reg;
        who0  = q_item.first ? '0 : who_reg;
        perm0 = q_item.first ? '0 : perm_reg;
        err0  = q_item.first ? 1'b0 : err_reg;
        wm0   = q_item.first ? q_item.start_mode : wm_reg;
    end

    // decode of the grammar position
    always_comb begin
        is_nul      = (cls == CL_NUL);
        in_oct      = (ph0 == PH_OCTAL);
        oct_digit   = in_oct && (cls == CL_DIGIT);
        who_path    = (in_oct && !oct_digit && !is_nul) || (ph0 == PH_WHO);
        who_letter  = who_path && (cls == CL_U || cls == CL_G || cls == CL_O || cls == CL_A);
        pf_copy     = (ph0 == PH_PFIRST) && (cls == CL_U || cls == CL_G || cls == CL_O);
        perm_path   = ((ph0 == PH_PFIRST) && !pf_copy) || (ph0 == PH_PERM);
        perm_letter = perm_path && (cls == CL_R || cls == CL_W || cls == CL_XL ||
                                    cls == CL_XU || cls == CL_S || cls == CL_T);
        ce          = (who_path && !who_letter) || (perm_path && !perm_letter)
                      || (ph0 == PH_AFTER);
        ce_op       = ce && (cls == CL_ADD || cls == CL_SUB || cls == CL_SET);
        ce_comma    = ce && (cls == CL_COMMA);
        emit        = is_nul && (in_oct || ce || (ph0 == PH_ERROR));
    end

    // next phase
    always_comb begin
        phase_next = ph0;
        if (emit) begin
            phase_next = PH_OCTAL;
        end else if (who_letter) begin
            phase_next = PH_WHO;
        end else if (pf_copy) begin
            phase_next = PH_AFTER;
        end else if (perm_letter) begin
            phase_next = PH_PERM;
        end else if (ce_op) begin
            phase_next = PH_PFIRST;
        end else if (ce_comma) begin
            phase_next = PH_WHO;
        end else if (ce) begin
            phase_next = PH_ERROR;
        end
    end

    // datapath
    always_comb begin
        case (cls)
            CL_U:    who_lmask = MASK_USER;
            CL_G:    who_lmask = MASK_GROUP;
            CL_O:    who_lmask = MASK_OTHER;
            default: who_lmask = MASK_ALL;
        endcase

        x_ok = ((wm0 & TYPE_FIELD) == TYPE_DIR) || ((wm0[PERM_W-1:0] & BIT_EXEC) != '0);
        case (cls)
            CL_R:    perm_lbits = BIT_READ;
            CL_W:    perm_lbits = BIT_WRITE;
            CL_XL:   perm_lbits = BIT_EXEC;
            CL_XU:   perm_lbits = x_ok ? BIT_EXEC : '0;
            CL_S:    perm_lbits = BIT_SETID;
            default: perm_lbits = BIT_STICKY;
        endcase

        case (cls)
            CL_ADD:  op_sel = OP_ADD;
            CL_SUB:  op_sel = OP_SUB;
            default: op_sel = OP_SET;
        endcase

        case (cls)
            CL_U:    cpy = wm0[8:6];
            CL_G:    cpy = wm0[5:3];
            default: cpy = wm0[2:0];
        endcase

        who_base   = in_oct ? '0 : who0;
        apply_en   = pf_copy || (perm_path && !perm_letter);
        apply_bits = pf_copy ? {3'b000, cpy, cpy, cpy} : perm0;
        apply_t    = apply_bits & who0;
        case (op0)
            OP_ADD:  wm_applied = wm0 | {4'b0000, apply_t};
            OP_SUB:  wm_applied = wm0 & ~{4'b0000, apply_t};
            OP_SET:  wm_applied = (wm0 & ~{4'b0000, who0}) | {4'b0000, apply_t};
            default: wm_applied = wm0;
        endcase

        if (oct_digit || emit) begin
            oct_next = emit ? '0 : {oct0[MODE_W-4:0], q_item.digit};
        end else begin
            oct_next = oct0;
        end

        if (in_oct && is_nul) begin
            wm_next = oct0;
        end else if (apply_en) begin
            wm_next = wm_applied;
        end else begin
            wm_next = wm0;
        end

        if (emit || ce_comma) begin
            who_next = '0;
        end else if (who_letter) begin
            who_next = who_base | who_lmask;
        end else if (who_path) begin
            who_next = (who_base == '0) ? (MASK_ALL & ~umask) : who_base;
        end else begin
            who_next = who0;
        end

        if (emit) begin
            op_next = OP_NONE;
        end else if (ce_op) begin
            op_next = op_sel;
        end else begin
            op_next = op0;
        end

        if (emit || ce_op) begin
            perm_next = '0;
        end else if (perm_letter) begin
            perm_next = perm0 | perm_lbits;
        end else begin
            perm_next = perm0;
        end

        if (emit) begin
            err_next = 1'b0;
        end else if (ce && !ce_op && !ce_comma) begin
            err_next = 1'b1;
        end else begin
            err_next = err0;
        end
    end

    // result register
    always_comb begin
        m_valid_next    = m_valid_reg && !m_ready;
        m_new_mode_next = m_new_mode_reg;
        m_invalid_next  = m_invalid_reg;
        if (q_pop && emit) begin
            m_valid_next    = 1'b1;
            m_new_mode_next = wm_next;
            m_invalid_next  = in_oct ? 1'b0 : (ce ? err0 : 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_OCTAL;
            op_reg      <= OP_NONE;
            oct_reg     <= '0;
            who_reg     <= '0;
            perm_reg    <= '0;
            wm_reg      <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                oct_reg   <= oct_next;
                who_reg   <= who_next;
                perm_reg  <= perm_next;
                wm_reg    <= wm_next;
                err_reg   <= err_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_new_mode_reg <= m_new_mode_next;
        m_invalid_reg  <= m_invalid_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_new_mode = m_new_mode_reg;
    assign m_invalid  = m_invalid_reg;

endmodule

### sv/symbolic_mode_parser_unit.sv
// Top level of the symbolic mode parser: umask register, front, queue and back.
//
// Use: a chmod mode string enters on the s_ channel one character per
// transfer, s_is_first high on its first character (s_start_mode is taken
// then), and a zero character ends it. One transfer on the m_ channel per
// string carries m_new_mode and m_invalid; other characters give none.
// Path: the terminating zero is written into the queue, then the back end
// pops it into the result register once that register is free or m_ready
// is seen. Throughput: one character per cycle while s_ready is high, taken
// by the clause parser in the back end.
// A two-entry queue lets the front keep taking characters while the back
// waits on a stalled m_ready; s_ready drops only when that queue is full.
// The result register holds its payload until m_ready is seen.
// Reset (aresetn low, synchronous) empties the queue, clears the parse
// state and the mode to zero, drops m_valid and sets umask_reg to 022.
// umask_reg is written over the APB port where paddr[2] is 0; write it only
// while no string is in flight.
module symbolic_mode_parser_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [smp_pkg::PADDR_W-1:0]   paddr,
    input  logic [smp_pkg::PDATA_W-1:0]   pwdata,
    output logic [smp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_symbol,
    input  logic                          s_is_first,
    input  logic [15:0]                   s_start_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_new_mode,
    output logic                          m_invalid
);
    import smp_pkg::*;

    logic [UMASK_W-1:0] umask_reg, umask_next;
    logic               cfg_wr;
    item_t              push_item, pop_item;
    q_status_t          q_status;
    logic               q_push, q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UMASK);

    always_comb begin
        umask_next = cfg_wr ? pwdata[UMASK_W-1:0] : umask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            umask_reg <= UMASK_RESET;
        end else begin
            umask_reg <= umask_next;
        end
    end

    assign prdata = (paddr[2] == REG_UMASK) ? {{(PDATA_W-UMASK_W){1'b0}}, umask_reg} : '0;

    smp_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_is_first   (s_is_first),
        .s_start_mode (s_start_mode),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    smp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (push_item),
        .pop      (q_pop),
        .item_out (pop_item),
        .status   (q_status)
    );

    smp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_item     (pop_item),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .umask      (umask_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_new_mode (m_new_mode),
        .m_invalid  (m_invalid)
    );

endmodule

### sv/smp_checker.sv
// Port-level checker of the symbolic mode parser and its bind.
`include "symbolic_mode_parser_unit_macros.svh"

module smp_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [smp_pkg::PADDR_W-1:0]   paddr,
    input logic [smp_pkg::PDATA_W-1:0]   pwdata,
    input logic [smp_pkg::PDATA_W-1:0]   prdata,
    input logic                          pready,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [7:0]                    s_symbol,
    input logic                          s_is_first,
    input logic [15:0]                   s_start_mode,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [15:0]                   m_new_mode,
    input logic                          m_invalid
);
    import smp_pkg::*;

    logic               umask_sel;
    logic               umask_wr;
    logic [PDATA_W-1:0] wr_value;
    logic [MODE_W:0]    m_payload;

    assign umask_sel = (paddr[2] == REG_UMASK);
    assign umask_wr  = psel && penable && pwrite && pready && umask_sel;
    assign wr_value  = PDATA_W'(pwdata[UMASK_W-1:0]);
    assign m_payload = {m_new_mode, m_invalid};

    // stalled result holds
    `SMP_ASSERT_NXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_payload))

    // reset drops the result channel
    `SMP_ASSERT_RST(a_rst, !aresetn, !m_valid)

    // a umask write reads back on the next cycle
    `SMP_ASSERT_IMP(a_readback, $past(aresetn && umask_wr) && umask_sel, prdata == $past(wr_value))

    // unused address reads zero, port never waits
    `SMP_ASSERT_IMP(a_unused, !umask_sel, prdata == '0 && pready)

endmodule

bind symbolic_mode_parser_unit smp_port_checker u_smp_checker (.*);

### tb/smp_checker.sv
// Mode-string checker: tracks umask, predicts each mode result and compares it with the m_ channel.
module smp_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [smp_pkg::PADDR_W-1:0] paddr,
    input  logic [smp_pkg::PDATA_W-1:0] pwdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [7:0]                  s_symbol,
    input  logic                        s_is_first,
    input  logic [15:0]                 s_start_mode,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [15:0]                 m_new_mode,
    input  logic                        m_invalid,
    output int                          mismatches,
    output int                          pending,
    output int                          modes_seen,
    output int                          invalid_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              inv;
    } mode_result_t;

    mode_result_t        expected_modes[$];
    logic [UMASK_W-1:0]  umask_cfg;
    phase_t              parse_phase;
    logic [MODE_W-1:0]   octal_acc;
    logic [PERM_W-1:0]   who_bits;
    op_t                 op_pending;
    logic [PERM_W-1:0]   perm_acc;
    logic [MODE_W-1:0]   cur_mode;
    logic                garbage_seen;

    initial begin
        mismatches   = 0;
        pending      = 0;
        modes_seen   = 0;
        invalid_seen = 0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns  MISMATCH %s: got %o, expected %o", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    task automatic clear_parse();
        parse_phase  = PH_OCTAL;
        octal_acc    = '0;
        who_bits     = '0;
        op_pending   = OP_NONE;
        perm_acc     = '0;
        garbage_seen = 1'b0;
    endtask

    task automatic post_mode(input logic inv);
        mode_result_t r;
        r.mode = cur_mode;
        r.inv  = inv;
        expected_modes.push_back(r);
        clear_parse();
    endtask

    task automatic apply_perm(input logic [PERM_W-1:0] bits);
        logic [PERM_W-1:0] t;
        t = bits & who_bits;
        case (op_pending)
            OP_ADD: cur_mode[PERM_W-1:0] = cur_mode[PERM_W-1:0] | t;
            OP_SUB: cur_mode[PERM_W-1:0] = cur_mode[PERM_W-1:0] & ~t;
            OP_SET: cur_mode[PERM_W-1:0] = (cur_mode[PERM_W-1:0] & ~who_bits) | t;
            default: ;
        endcase
    endtask

    task automatic end_clause(input logic [7:0] c);
        case (c)
            "+": begin
                op_pending  = OP_ADD;
                perm_acc    = '0;
                parse_phase = PH_PFIRST;
            end
            "-": begin
                op_pending  = OP_SUB;
                perm_acc    = '0;
                parse_phase = PH_PFIRST;
            end
            "=": begin
                op_pending  = OP_SET;
                perm_acc    = '0;
                parse_phase = PH_PFIRST;
            end
            ",": begin
                who_bits    = '0;
                parse_phase = PH_WHO;
            end
            CH_NUL: post_mode(garbage_seen);
            default: begin
                garbage_seen = 1'b1;
                parse_phase  = PH_ERROR;
            end
        endcase
    endtask

    task automatic parse_symbol(input logic [7:0] c, input logic first,
                                input logic [MODE_W-1:0] start);
        phase_t     ph;
        logic [2:0] copy;
        if (first) begin
            clear_parse();
            cur_mode = start;
        end
        ph = parse_phase;
        if (ph == PH_OCTAL) begin
            if (c >= "0" && c <= "7") begin
                octal_acc = (octal_acc << 3) + {13'b0, c[2:0]};
                return;
            end
            if (c == CH_NUL) begin
                cur_mode = octal_acc;
                post_mode(1'b0);
                return;
            end
            who_bits    = '0;
            ph          = PH_WHO;
            parse_phase = PH_WHO;
        end
        if (ph == PH_WHO) begin
            case (c)
                "u": who_bits = who_bits | MASK_USER;
                "g": who_bits = who_bits | MASK_GROUP;
                "o": who_bits = who_bits | MASK_OTHER;
                "a": who_bits = who_bits | MASK_ALL;
                default: begin
                    if (who_bits == '0)
                        who_bits = MASK_ALL & ~umask_cfg;
                    end_clause(c);
                end
            endcase
            return;
        end
        if (ph == PH_PFIRST) begin
            if (c == "u" || c == "g" || c == "o") begin
                copy = (c == "u") ? cur_mode[8:6] : (c == "g") ? cur_mode[5:3] : cur_mode[2:0];
                apply_perm({3'b000, copy, copy, copy});
                parse_phase = PH_AFTER;
                return;
            end
            ph          = PH_PERM;
            parse_phase = PH_PERM;
        end
        if (ph == PH_PERM) begin
            case (c)
                "r": perm_acc = perm_acc | BIT_READ;
                "w": perm_acc = perm_acc | BIT_WRITE;
                "x": perm_acc = perm_acc | BIT_EXEC;
                "X": begin
                    if ((cur_mode & TYPE_FIELD) == TYPE_DIR ||
                        (cur_mode[PERM_W-1:0] & BIT_EXEC) != '0)
                        perm_acc = perm_acc | BIT_EXEC;
                end
                "s": perm_acc = perm_acc | BIT_SETID;
                "t": perm_acc = perm_acc | BIT_STICKY;
                default: begin
                    apply_perm(perm_acc);
                    end_clause(c);
                end
            endcase
            return;
        end
        if (ph == PH_AFTER) begin
            end_clause(c);
            return;
        end
        if (c == CH_NUL)
            post_mode(1'b1);
    endtask

    task automatic check_result();
        mode_result_t want;
        if (expected_modes.size() == 0) begin
            report_mismatch("result transfer with no string pending", m_new_mode, '0);
            return;
        end
        want = expected_modes.pop_front();
        modes_seen = modes_seen + 1;
        if (m_invalid)
            invalid_seen = invalid_seen + 1;
        if (m_new_mode !== want.mode)
            report_mismatch("new_mode", m_new_mode, want.mode);
        if (m_invalid !== want.inv)
            report_mismatch("invalid", {15'b0, m_invalid}, {15'b0, want.inv});
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            umask_cfg = UMASK_RESET;
            cur_mode  = '0;
            clear_parse();
            expected_modes.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_UMASK)
                umask_cfg = pwdata[UMASK_W-1:0];
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                parse_symbol(s_symbol, s_is_first, s_start_mode);
        end
        pending = expected_modes.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, mode-string stimulus, umask writes, receiver stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smp_pkg::*;

    localparam int ITEM_TARGET  = 2000;
    localparam int PHASES       = 6;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE       = 4;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [PADDR_W-1:0] UMASK_ADDR = {REG_UMASK, 2'b00};

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_symbol;
    logic                s_is_first;
    logic [15:0]         s_start_mode;
    logic                m_valid;
    logic                m_ready;
    logic [15:0]         m_new_mode;
    logic                m_invalid;

    int mismatches;
    int pending;
    int modes_seen;
    int invalid_seen;

    int items_sent;
    int umask_writes;
    int burst_left;
    int hold_reqs;
    int quiet_cycles;

    logic [7:0] mode_text[$];
    string who_letters  = "ugoa";
    string op_letters   = "+-=";
    string copy_letters = "ugo";
    string perm_letters = "rwxXst";

    symbolic_mode_parser_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_is_first   (s_is_first),
        .s_start_mode (s_start_mode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_mode   (m_new_mode),
        .m_invalid    (m_invalid)
    );

    smp_checker mode_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_is_first   (s_is_first),
        .s_start_mode (s_start_mode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_mode   (m_new_mode),
        .m_invalid    (m_invalid),
        .mismatches   (mismatches),
        .pending      (pending),
        .modes_seen   (modes_seen),
        .invalid_seen (invalid_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: changing stall styles, plus long hold-offs on request
    initial begin
        int holds_done;
        int style;
        int style_left;
        holds_done = 0;
        style      = 0;
        style_left = 100;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_reqs) begin
                holds_done = holds_done + 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 200);
                end
                style_left = style_left - 1;
                case (style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic first,
                               input logic [15:0] start);
        int gap;
        s_valid      <= 1'b1;
        s_symbol     <= sym;
        s_is_first   <= first;
        s_start_mode <= start;
        do @(posedge aclk); while (!s_ready);
        items_sent = items_sent + 1;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic send_text(input string body, input logic [15:0] start);
        for (int i = 0; i < body.len(); i++)
            send_symbol(body[i], i == 0, start);
        send_symbol(CH_NUL, body.len() == 0, start);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_umask(input logic [UMASK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= UMASK_ADDR;
        pwdata  <= {{(PDATA_W-UMASK_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        umask_writes = umask_writes + 1;
        @(negedge aclk);
    endtask

    task automatic build_mode_text(output logic broken);
        int kind;
        int pos;
        mode_text.delete();
        kind   = $urandom_range(0, 99);
        broken = 1'b0;
        if (kind < 3) begin
            // empty string
        end else if (kind < 12) begin
            repeat ($urandom_range(1, 7))
                mode_text.push_back(8'h30 | 8'($urandom_range(0, 7)));
        end else if (kind < 20) begin
            broken = 1'b1;
            repeat ($urandom_range(1, 10))
                mode_text.push_back(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    mode_text.push_back(8'h30 | 8'($urandom_range(0, 7)));
            for (int cl = $urandom_range(1, 3); cl > 0; cl--) begin
                repeat ($urandom_range(0, 3))
                    mode_text.push_back(who_letters[$urandom_range(0, 3)]);
                for (int op = $urandom_range(1, 3); op > 0; op--) begin
                    mode_text.push_back(op_letters[$urandom_range(0, 2)]);
                    if ($urandom_range(0, 4) == 0)
                        mode_text.push_back(copy_letters[$urandom_range(0, 2)]);
                    else
                        repeat ($urandom_range(0, 4))
                            mode_text.push_back(perm_letters[$urandom_range(0, 5)]);
                end
                if (cl > 1)
                    mode_text.push_back(",");
            end
            if (kind >= 85) begin
                broken = 1'b1;
                pos = $urandom_range(0, mode_text.size() - 1);
                mode_text[pos] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic send_random_string();
        logic        broken;
        logic        first;
        logic        first_here;
        logic [15:0] start;
        build_mode_text(broken);
        first = ($urandom_range(0, 9) != 0);
        start = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
            start[15:12] = TYPE_DIR[15:12];
        for (int i = 0; i < mode_text.size(); i++) begin
            first_here = (i == 0) ? first : (broken && $urandom_range(0, 15) == 0);
            send_symbol(mode_text[i], first_here, (i == 0) ? start : 16'($urandom));
        end
        send_symbol(CH_NUL, first && mode_text.size() == 0, start);
    endtask

    initial begin
        logic [UMASK_W-1:0] umask_plan[PHASES];
        int                 phase_goal;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_symbol     = '0;
        s_is_first   = 1'b0;
        s_start_mode = '0;
        items_sent   = 0;
        umask_writes = 0;
        burst_left   = 0;
        hold_reqs    = 0;
        quiet_cycles = 0;
        umask_plan   = '{12'o0000, 12'o7777, 12'($urandom_range(0, 4095)),
                         12'($urandom_range(0, 4095)), 12'o0022, 12'($urandom_range(0, 4095))};

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed strings under the reset umask
        send_text("", 16'o100644);
        send_text("777777", 16'o000000);
        send_text("+X", 16'o040600);
        send_text("go=u", 16'o100754);
        send_text("a+s-wx,u+t", 16'o100777);
        send_text("ux", 16'o100644);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            write_umask(umask_plan[ph]);
            phase_goal = items_sent + ITEM_TARGET / PHASES;
            while (items_sent < phase_goal) begin
                send_random_string();
                if (ph == 2 && hold_reqs == 0 && items_sent > phase_goal - 200)
                    hold_reqs = hold_reqs + 1;
                if (ph == 3 && items_sent > phase_goal - 150 && pending != 0) begin
                    s_valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Run covered %0d characters and %0d mode results (%0d marked invalid)",
                 items_sent, modes_seen, invalid_seen);
        $display("across %0d umask settings, with receiver stalls and one long hold-off.",
                 umask_writes + 1);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
